// ----- rtl/core/utf8u16_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package utf8u16_pkg;

    localparam int CP_W        = 21;
    localparam int UNIT_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SUPP    = 21'h010000;
    localparam logic [5:0]      HI_SURR_TAG = 6'b110110;
    localparam logic [5:0]      LO_SURR_TAG = 6'b110111;

    typedef struct packed {
        logic            pair;
        logic [CP_W-1:0] cp;
    } cp_entry_t;

endpackage

// ----- rtl/core/utf8u16_front.sv -----
// Front stage: accepts UTF-8 bytes, assembles code points and classifies them.
module utf8u16_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [7:0]                    data_byte,
    input  logic                          end_of_string,
    output logic                          push,
    output utf8u16_pkg::cp_entry_t        push_entry
);
    import utf8u16_pkg::*;

    logic [1:0]      pending_reg;
    logic [1:0]      pending_next;
    logic [CP_W-1:0] partial_reg;
    logic [CP_W-1:0] partial_next;
    logic [CP_W-1:0] cp_done;
    logic            done;

    always_comb
    begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        cp_done      = '0;
        done         = 1'b0;
        if (pending_reg != 2'd0)
        begin
            cp_done      = {partial_reg[CP_W-7:0], data_byte[5:0]};
            pending_next = pending_reg - 2'd1;
            partial_next = cp_done;
            if (pending_next == 2'd0)
            begin
                done         = 1'b1;
                partial_next = '0;
            end
        end
        else if (data_byte[7] == 1'b0)
        begin
            cp_done = {{(CP_W-BYTE_W){1'b0}}, data_byte};
            done    = 1'b1;
        end
        else if (data_byte[7:5] == 3'b110)
        begin
            partial_next = {{(CP_W-5){1'b0}}, data_byte[4:0]};
            pending_next = 2'd1;
        end
        else if (data_byte[7:4] == 4'b1110)
        begin
            partial_next = {{(CP_W-4){1'b0}}, data_byte[3:0]};
            pending_next = 2'd2;
        end
        else if (data_byte[7:3] == 5'b11110)
        begin
            partial_next = {{(CP_W-3){1'b0}}, data_byte[2:0]};
            pending_next = 2'd3;
        end
        if (end_of_string)
        begin
            pending_next = 2'd0;
            partial_next = '0;
        end
    end

    assign push            = accept && done && (cp_done <= CP_MAX);
    assign push_entry.cp   = cp_done;
    assign push_entry.pair = |cp_done[CP_W-1:UNIT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            partial_reg <= '0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
        end
    end

endmodule

// ----- rtl/core/utf8u16_queue.sv -----
// Small FIFO of classified code points between the front and back stages.
module utf8u16_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  utf8u16_pkg::cp_entry_t        push_entry,
    input  logic                          pop,
    output utf8u16_pkg::cp_entry_t        pop_entry,
    output logic                          full,
    output logic                          empty
);
    import utf8u16_pkg::*;

    cp_entry_t         mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/core/utf8u16_back.sv -----
// Back stage: turns queued code points into UTF-16 words in an output register.
module utf8u16_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  utf8u16_pkg::cp_entry_t        head,
    input  logic                          empty,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [15:0]                   code_unit,
    output logic                          run_last
);
    import utf8u16_pkg::*;

    logic               valid_reg;
    logic [UNIT_W-1:0]  unit_reg;
    logic               last_reg;
    logic               second_reg;
    logic               load;
    logic [CP_W-1:0]    offset;
    logic [UNIT_W-1:0]  unit_next;
    logic               last_next;

    assign load   = !empty && (!valid_reg || out_ready);
    assign offset = head.cp - CP_SUPP;

    always_comb
    begin
        if (!head.pair)
        begin
            unit_next = head.cp[UNIT_W-1:0];
            last_next = 1'b1;
        end
        else if (!second_reg)
        begin
            unit_next = {HI_SURR_TAG, offset[19:10]};
            last_next = 1'b0;
        end
        else
        begin
            unit_next = {LO_SURR_TAG, offset[9:0]};
            last_next = 1'b1;
        end
    end

    assign pop = load && last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg  <= 1'b1;
                second_reg <= !last_next;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            unit_reg <= unit_next;
            last_reg <= last_next;
        end
    end

    assign out_valid = valid_reg;
    assign code_unit = unit_reg;
    assign run_last  = last_reg;

endmodule

// ----- rtl/core/utf8_to_utf16_decoder_core.sv -----
// Top level of the UTF-8 to UTF-16 transcoder: front stage, queue and back stage.
//
//  Channel   Direction  Word contents
//  s_axis    in         tdata = data_byte[7:0], tlast = end_of_string
//  m_axis    out        tdata = code_unit[15:0], tlast = run_last
//
// One input byte is taken per cycle while the four-entry queue has room.
// A code point of the basic plane leaves as one word, a surrogate pair as two words,
// and the output port carries one word per cycle while m_axis_tready is high.
// The output word sits in a register; the input side keeps running while it stalls, until the queue is full.
// Reset clears the decoder state, the queue pointers and the output valid flag, but not the output word.
module utf8_to_utf16_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] code_unit
    output logic        m_axis_tlast
);
    import utf8u16_pkg::*;

    logic      accept;
    logic      push;
    logic      pop;
    logic      full;
    logic      empty;
    cp_entry_t push_entry;
    cp_entry_t head;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;

    utf8u16_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (s_axis_tdata),
        .end_of_string (s_axis_tlast),
        .push          (push),
        .push_entry    (push_entry)
    );

    utf8u16_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (head),
        .full       (full),
        .empty      (empty)
    );

    utf8u16_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .code_unit (m_axis_tdata),
        .run_last  (m_axis_tlast)
    );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the UTF-8 to UTF-16 transcoder core.
import utf8u16_pkg::*;

typedef struct {
    logic [UNIT_W-1:0] unit;
    logic              last;
} utf16_word_t;

class utf16_scoreboard;
    logic [1:0]      bytes_left;
    logic [CP_W-1:0] cp_accum;
    utf16_word_t     expected_units[$];
    int              errors;

    function new();
        bytes_left = 2'd0;
        cp_accum   = '0;
        errors     = 0;
    endfunction

    task report_mismatch(string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        errors++;
    endtask

    function void push_unit(logic [UNIT_W-1:0] unit, logic last);
        utf16_word_t w;
        w.unit = unit;
        w.last = last;
        expected_units.insert(expected_units.size(), w);
    endfunction

    function void push_codepoint(logic [CP_W-1:0] cp);
        logic [CP_W-1:0] offset;
        if (cp <= 21'h00FFFF)
        begin
            push_unit(cp[15:0], 1'b1);
        end
        else if (cp <= CP_MAX)
        begin
            offset = cp - CP_SUPP;
            push_unit(16'hD800 + {6'd0, offset[19:10]}, 1'b0);
            push_unit(16'hDC00 + {6'd0, offset[9:0]}, 1'b1);
        end
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b, logic eos);
        if (bytes_left != 2'd0)
        begin
            cp_accum   = {cp_accum[14:0], b[5:0]};
            bytes_left = bytes_left - 2'd1;
            if (bytes_left == 2'd0)
            begin
                push_codepoint(cp_accum);
                cp_accum = '0;
            end
        end
        else if (b <= 8'h7F)
        begin
            push_codepoint({13'd0, b});
        end
        else if (b[7:5] == 3'b110)
        begin
            cp_accum   = {16'd0, b[4:0]};
            bytes_left = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            cp_accum   = {17'd0, b[3:0]};
            bytes_left = 2'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            cp_accum   = {18'd0, b[2:0]};
            bytes_left = 2'd3;
        end
        if (eos)
        begin
            bytes_left = 2'd0;
            cp_accum   = '0;
        end
    endfunction

    task check_unit(logic [UNIT_W-1:0] unit, logic last);
        utf16_word_t want;
        if (expected_units.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word %h last %b", unit, last));
        end
        else
        begin
            want = expected_units.pop_front();
            if (unit !== want.unit)
                report_mismatch($sformatf("code unit %h, expected %h", unit, want.unit));
            if (last !== want.last)
                report_mismatch($sformatf("last flag %b, expected %b on unit %h",
                                          last, want.last, want.unit));
        end
    endtask
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1600;
    localparam int N_DIRECTED  = 27;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    utf16_scoreboard sb = new();
    int items_sent = 0;
    int burst_left = 0;

    // Each entry is {end_of_string, data_byte}.
    logic [8:0] directed_bytes [N_DIRECTED] = '{
        9'h000, 9'h17F,
        9'h0C2, 9'h0A9,
        9'h0EF, 9'h0BF, 9'h0BF,
        9'h0F0, 9'h090, 9'h080, 9'h080,
        9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
        9'h080, 9'h0FF,
        9'h0C0, 9'h080,
        9'h0ED, 9'h0A0, 9'h080,
        9'h0E2, 9'h0C3, 9'h081,
        9'h0E2, 9'h182
    };

    utf8_to_utf16_decoder_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_unit(m_axis_tdata, m_axis_tlast);
        end
    end

    task automatic send_byte(logic [7:0] b, logic eos);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_random_char();
        logic [7:0]  seq [4];
        logic [31:0] rnd;
        int kind;
        int len;
        int i;
        kind = $urandom_range(0, 9);
        len  = $urandom_range(1, 4);
        rnd  = $urandom;
        case (len)
            1: seq[0] = {1'b0, rnd[6:0]};
            2: seq[0] = {3'b110, rnd[4:0]};
            3: seq[0] = {4'b1110, rnd[3:0]};
            default: seq[0] = {5'b11110, rnd[2:0]};
        endcase
        for (i = 1; i < 4; i++)
        begin
            rnd    = $urandom;
            seq[i] = {2'b10, rnd[5:0]};
        end
        if (kind == 0)
        begin
            len    = 1;
            seq[0] = 8'($urandom_range(0, 255));
        end
        else if (kind == 1 && len > 1)
        begin
            seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
        end
        for (i = 0; i < len; i++)
            send_byte(seq[i], $urandom_range(0, 19) == 0);
    endtask

    initial
    begin
        repeat (120)
        begin
            @(negedge clk);
            m_axis_tready <= 1'b1;
        end
        repeat (400)
        begin
            @(negedge clk);
            m_axis_tready <= 1'b0;
        end
        forever
        begin
            int mode;
            int span;
            int phase;
            mode = $urandom_range(0, 3);
            span = $urandom_range(50, 300);
            for (phase = 0; phase < span; phase++)
            begin
                @(negedge clk);
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= (phase % 4) != 3;
                    default: m_axis_tready <= $urandom_range(0, 7) == 0;
                endcase
            end
        end
    end

    initial
    begin
        #5000000;
        $display("utf8_to_utf16_decoder_core test failed");
        $finish;
    end

    initial
    begin
        int k;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        for (k = 0; k < N_DIRECTED; k++)
            send_byte(directed_bytes[k][7:0], directed_bytes[k][8]);
        while (items_sent < ITEM_TARGET + N_DIRECTED)
            send_random_char();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_units.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.expected_units.size() != 0)
            sb.report_mismatch("expected words left over");
        if (sb.errors == 0)
            $display("utf8_to_utf16_decoder_core test passed");
        else
            $display("utf8_to_utf16_decoder_core test failed");
        $finish;
    end
endmodule
